@@ src/icf_pkg.sv @@
// ----------------------------------------------------------------------------
// icf_pkg
// Shared widths, register codes, reset values and the CORDIC arctangent table
// of the IMU complementary filter.
// ----------------------------------------------------------------------------
`default_nettype none

package icf_pkg;

   localparam int ANGLE_FRAC_BITS_DEF = 16;
   localparam int CORDIC_STEPS_DEF    = 20;

   localparam int RAW_W       = 16;
   localparam int INTERVAL_W  = 20;
   localparam int ANGLE_OUT_W = 26;
   localparam int WEIGHT_W    = 17;
   localparam int CPD_W       = 16;
   localparam int CSR_IDX_W   = 4;
   localparam int CSR_DATA_W  = 17;

   localparam int TAB_FRAC = 32;
   localparam int TAB_W    = 38;

   localparam int MICROS_W = 20;
   localparam logic [MICROS_W-1:0] MICROS = 20'd1000000;

   localparam logic [WEIGHT_W-1:0] UNIT_WEIGHT  = 17'd65536;
   localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 17'd64225;
   localparam logic [CPD_W-1:0]    CPD_RESET    = 16'd131;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GYRO_WEIGHT = 4'd0,
      CSR_GYRO_CPD    = 4'd1
   } csr_index_type;

   // atan(2^-i) in units of 2^-32 degree
   function automatic logic [TAB_W-1:0] atan_entry(input logic [4:0] idx);
      logic [TAB_W-1:0] v;
      case (idx)
         5'd0:  v = 38'd193273528320;
         5'd1:  v = 38'd114096026022;
         5'd2:  v = 38'd60285206653;
         5'd3:  v = 38'd30601712202;
         5'd4:  v = 38'd15360239180;
         5'd5:  v = 38'd7687607525;
         5'd6:  v = 38'd3844741810;
         5'd7:  v = 38'd1922488225;
         5'd8:  v = 38'd961258780;
         5'd9:  v = 38'd480631223;
         5'd10: v = 38'd240315841;
         5'd11: v = 38'd120157949;
         5'd12: v = 38'd60078978;
         5'd13: v = 38'd30039490;
         5'd14: v = 38'd15019745;
         5'd15: v = 38'd7509872;
         5'd16: v = 38'd3754936;
         5'd17: v = 38'd1877468;
         5'd18: v = 38'd938734;
         5'd19: v = 38'd469367;
         5'd20: v = 38'd234684;
         5'd21: v = 38'd117342;
         5'd22: v = 38'd58671;
         5'd23: v = 38'd29335;
         5'd24: v = 38'd14668;
         5'd25: v = 38'd7334;
         5'd26: v = 38'd3667;
         5'd27: v = 38'd1833;
         5'd28: v = 38'd917;
         5'd29: v = 38'd458;
         5'd30: v = 38'd229;
         default: v = 38'd115;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

@@ src/icf_req_if.sv @@
// ----------------------------------------------------------------------------
// icf_req_if
// Sample channel: raw accelerometer and gyro counts plus the sample interval.
// ----------------------------------------------------------------------------
`default_nettype none

interface icf_req_if;
   import icf_pkg::*;

   logic                         valid;
   logic                         ready;
   logic signed [RAW_W-1:0]      accel_x;
   logic signed [RAW_W-1:0]      accel_y;
   logic signed [RAW_W-1:0]      accel_z;
   logic signed [RAW_W-1:0]      gyro_x;
   logic signed [RAW_W-1:0]      gyro_y;
   logic        [INTERVAL_W-1:0] interval_us;

   modport source (output valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, interval_us,
                   input ready);
   modport sink   (input valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, interval_us,
                   output ready);
endinterface

`default_nettype wire

@@ src/icf_rsp_if.sv @@
// ----------------------------------------------------------------------------
// icf_rsp_if
// Result channel: filtered pitch and roll angles.
// ----------------------------------------------------------------------------
`default_nettype none

interface icf_rsp_if;
   import icf_pkg::*;

   logic                          valid;
   logic                          ready;
   logic signed [ANGLE_OUT_W-1:0] pitch_out;
   logic signed [ANGLE_OUT_W-1:0] roll_out;

   modport source (output valid, pitch_out, roll_out, input ready);
   modport sink   (input valid, pitch_out, roll_out, output ready);
endinterface

`default_nettype wire

@@ src/icf_cordic.sv @@
// ----------------------------------------------------------------------------
// icf_cordic
// Vectoring CORDIC atan2, one micro-rotation per cycle, result in degrees.
// ----------------------------------------------------------------------------
`default_nettype none

module icf_cordic #(
   parameter int ANGLE_FRAC_BITS = icf_pkg::ANGLE_FRAC_BITS_DEF,
   parameter int CORDIC_STEPS    = icf_pkg::CORDIC_STEPS_DEF,
   parameter int IN_W            = 25
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic signed [IN_W-1:0]            y_in,
   input  wire logic signed [IN_W-1:0]            x_in,
   output logic                                   busy,
   output logic                                   done,
   output logic signed [ANGLE_FRAC_BITS+9:0]      angle
);
   import icf_pkg::*;

   localparam int STEPS = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
   localparam int XY_W  = IN_W + 1 + 16 + 3;
   localparam int Z_W   = TAB_W + 3;
   localparam int SH    = TAB_FRAC - ANGLE_FRAC_BITS;
   localparam int ACC_W = ANGLE_FRAC_BITS + 10;
   localparam logic signed [Z_W-1:0] Z_QUARTER = Z_W'(90) <<< TAB_FRAC;
   localparam logic signed [Z_W-1:0] Z_HALF_LSB = Z_W'(1) <<< (SH - 1);

   logic signed [XY_W-1:0] x_ff, y_ff;
   logic signed [Z_W-1:0]  z_ff;
   logic [4:0]             k_ff;
   logic                   busy_ff, done_ff, zero_ff;

   logic signed [IN_W:0]   xi, yi, xr, yr;
   logic signed [Z_W-1:0]  zr, tab_s, z_round;
   logic signed [XY_W-1:0] dx, dy;

   // pre-rotate the left half plane by a quarter turn
   always_comb begin
      xi = (IN_W+1)'(x_in);
      yi = (IN_W+1)'(y_in);
      xr = xi;
      yr = yi;
      zr = '0;
      if (xi < 0) begin
         if (yi >= 0) begin
            xr = yi;
            yr = -xi;
            zr = Z_QUARTER;
         end else begin
            xr = -yi;
            yr = xi;
            zr = -Z_QUARTER;
         end
      end
   end

   assign dx      = y_ff >>> k_ff;
   assign dy      = x_ff >>> k_ff;
   assign tab_s   = signed'(Z_W'(atan_entry(k_ff)));
   assign z_round = (z_ff + Z_HALF_LSB) >>> SH;

   always_ff @(posedge clock) begin
      if (start) begin
         x_ff    <= XY_W'(xr) <<< 16;
         y_ff    <= XY_W'(yr) <<< 16;
         z_ff    <= zr;
         zero_ff <= (x_in == '0) && (y_in == '0);
         k_ff    <= '0;
      end else if (busy_ff) begin
         if (y_ff > 0) begin
            x_ff <= x_ff + dx;
            y_ff <= y_ff - dy;
            z_ff <= z_ff + tab_s;
         end else begin
            x_ff <= x_ff - dx;
            y_ff <= y_ff + dy;
            z_ff <= z_ff - tab_s;
         end
         k_ff <= k_ff + 5'd1;
      end
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
      end else if (busy_ff && (k_ff == 5'(STEPS - 1))) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b1;
      end else begin
         done_ff <= 1'b0;
      end
   end

   assign busy  = busy_ff;
   assign done  = done_ff;
   assign angle = zero_ff ? '0 : ACC_W'(z_round);

endmodule

`default_nettype wire

@@ src/icf_gyro_div.sv @@
// ----------------------------------------------------------------------------
// icf_gyro_div
// Two-lane restoring divider with a shared divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module icf_gyro_div #(
   parameter int NUM_W = 53,
   parameter int DEN_W = 36
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [DEN_W-1:0] den,
   input  wire logic [NUM_W-1:0] num_a,
   input  wire logic [NUM_W-1:0] num_b,
   output logic                  busy,
   output logic [NUM_W-1:0]      quo_a,
   output logic [NUM_W-1:0]      quo_b
);
   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [DEN_W-1:0] den_ff, ra_ff, rb_ff;
   logic [NUM_W-1:0] na_ff, nb_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic [DEN_W:0]   ta, tb;
   logic             ge_a, ge_b;

   assign ta   = {ra_ff, na_ff[NUM_W-1]};
   assign tb   = {rb_ff, nb_ff[NUM_W-1]};
   assign ge_a = ta >= {1'b0, den_ff};
   assign ge_b = tb >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (start) begin
         den_ff <= den;
         na_ff  <= num_a;
         nb_ff  <= num_b;
         ra_ff  <= '0;
         rb_ff  <= '0;
         cnt_ff <= '0;
      end else if (busy_ff) begin
         // the dividend shifts out the top as quotient bits shift in below
         ra_ff  <= ge_a ? DEN_W'(ta - {1'b0, den_ff}) : DEN_W'(ta);
         rb_ff  <= ge_b ? DEN_W'(tb - {1'b0, den_ff}) : DEN_W'(tb);
         na_ff  <= {na_ff[NUM_W-2:0], ge_a};
         nb_ff  <= {nb_ff[NUM_W-2:0], ge_b};
         cnt_ff <= cnt_ff + CNT_W'(1);
      end
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
      end else if (busy_ff && (cnt_ff == CNT_W'(NUM_W - 1))) begin
         busy_ff <= 1'b0;
      end
   end

   assign busy  = busy_ff;
   assign quo_a = na_ff;
   assign quo_b = nb_ff;

endmodule

`default_nettype wire

@@ src/imu_complementary_filter_top.sv @@
// ----------------------------------------------------------------------------
// imu_complementary_filter_top
// Pitch/roll complementary filter for a six-axis IMU.
// ----------------------------------------------------------------------------
// One sample is processed at a time. Accepted samples go through bit-serial
// multiplies (sum of squares, gyro*interval, scale*10^6), a square root at one
// root bit per cycle, two atan2 passes through the shared CORDIC and a
// bit-serial blend. The gyro divide runs alongside the square root and CORDIC
// passes; where it is longer than they are, the blend waits for it. A new
// sample is taken once the previous one has reached the result register, even
// while that result still waits to be read. Angles are in units of
// 2^-ANGLE_FRAC_BITS degree and saturate at +/-360 degrees.
// ----------------------------------------------------------------------------
`default_nettype none

module imu_complementary_filter_top #(
   parameter int ANGLE_FRAC_BITS = icf_pkg::ANGLE_FRAC_BITS_DEF,
   parameter int CORDIC_STEPS    = icf_pkg::CORDIC_STEPS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_wr_en,
   input  wire logic [icf_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [icf_pkg::CSR_DATA_W-1:0]    csr_wr_data,
   icf_req_if.sink                                req_chan,
   icf_rsp_if.source                              rsp_chan
);
   import icf_pkg::*;

   localparam int F         = ANGLE_FRAC_BITS;
   localparam int ANG_W     = F + 10;
   localparam int SQ_W      = 2 * RAW_W;
   localparam int ROOT_W    = 24;
   localparam int RAD_W     = 2 * ROOT_W;
   localparam int REM_W     = ROOT_W + 2;
   localparam int PROD_W    = RAW_W + INTERVAL_W;
   localparam int DEN_W     = CPD_W + MICROS_W;
   localparam int NUM_W     = PROD_W + F + 1;
   localparam int STEP_W    = NUM_W + 1;
   localparam int DIFF_W    = STEP_W + 2;
   localparam int BL_W      = DIFF_W + WEIGHT_W + 1;
   localparam int COR_IN_W  = ROOT_W + 1;
   localparam logic signed [ANG_W-1:0] LIMIT = ANG_W'(360) <<< F;
   localparam logic signed [BL_W-1:0]  ROUND_HALF = BL_W'(32768);

   typedef enum logic [2:0] {
      S_IDLE, S_MUL, S_SQRT, S_PITCH, S_ROLL, S_WAIT_DIV, S_BLEND, S_DONE
   } state_type;

   state_type state_ff;
   logic [4:0] cnt_ff;

   logic [WEIGHT_W-1:0] weight_ff;
   logic [CPD_W-1:0]    cpd_ff;
   logic signed [ANG_W-1:0] pitch_ff, roll_ff;

   logic signed [RAW_W-1:0] ax_ff, ay_ff, az_ff;
   logic gx_neg_ff, gy_neg_ff;

   logic [SQ_W-1:0]   mc_ax_ff, mc_az_ff, sq_ff;
   logic [RAW_W-1:0]  ml_ax_ff, ml_az_ff, ml_gx_ff, ml_gy_ff;
   logic [PROD_W-1:0] mc_dt_ff, pp_gx_ff, pp_gy_ff;
   logic [DEN_W-1:0]  mc_mic_ff, den_ff;
   logic [CPD_W-1:0]  ml_cpd_ff;

   logic [RAD_W-1:0]  rad_ff;
   logic [ROOT_W-1:0] root_ff;
   logic [REM_W-1:0]  rem_ff;

   logic cor_start_ff, div_start_ff;
   logic signed [ANG_W-1:0] acc_pitch_ff, acc_roll_ff;

   logic [WEIGHT_W-1:0]    w_sh_ff;
   logic signed [BL_W-1:0] dp_sh_ff, dr_sh_ff, sum_p_ff, sum_r_ff;

   logic rsp_valid_ff;
   logic signed [ANGLE_OUT_W-1:0] rsp_pitch_ff, rsp_roll_ff;

   logic [SQ_W-1:0]         sq_in;
   logic [REM_W+1:0]        rem_t, trial;
   logic                    sqrt_ge;
   logic [WEIGHT_W-1:0]     w_eff;
   logic [CPD_W-1:0]        cpd_eff;
   logic signed [COR_IN_W-1:0] cor_y, cor_x;
   logic cor_busy, cor_done;
   logic signed [ANG_W-1:0] cor_angle;
   logic [NUM_W-1:0]        num_p, num_r, quo_p, quo_r;
   logic                    div_busy;
   logic signed [STEP_W-1:0] step_p, step_r;
   logic signed [DIFF_W-1:0] diff_p, diff_r;
   logic signed [BL_W-1:0]  rnd_p, rnd_r, sat_p, sat_r;
   logic signed [ANG_W-1:0] pitch_in, roll_in;
   logic                    accept;
   logic                    cor_start_in, div_start_in, rsp_valid_in, rsp_load;

   function automatic logic [RAW_W-1:0] mag16(input logic signed [RAW_W-1:0] v);
      return v[RAW_W-1] ? RAW_W'(-v) : RAW_W'(v);
   endfunction

   function automatic logic signed [BL_W-1:0] clamp(input logic signed [BL_W-1:0] v);
      logic signed [BL_W-1:0] lim;
      lim = BL_W'(LIMIT);
      if (v > lim) begin
         return lim;
      end else if (v < -lim) begin
         return -lim;
      end
      return v;
   endfunction

   assign accept  = req_chan.valid && req_chan.ready;
   assign w_eff   = (weight_ff > UNIT_WEIGHT) ? UNIT_WEIGHT : weight_ff;
   assign cpd_eff = (cpd_ff == '0) ? CPD_W'(1) : cpd_ff;

   assign sq_in = sq_ff + (ml_ax_ff[0] ? mc_ax_ff : '0) + (ml_az_ff[0] ? mc_az_ff : '0);

   assign rem_t   = {rem_ff, rad_ff[RAD_W-1 -: 2]};
   assign trial   = {2'b00, root_ff, 2'b01};
   assign sqrt_ge = rem_t >= trial;

   // pitch: atan2(ay*256, root); roll: atan2(-ax, az)
   assign cor_y = (state_ff == S_ROLL) ? -COR_IN_W'(ax_ff) : (COR_IN_W'(ay_ff) <<< 8);
   assign cor_x = (state_ff == S_ROLL) ? COR_IN_W'(az_ff) : signed'({1'b0, root_ff});

   assign num_p = (NUM_W'(pp_gx_ff) << F) + NUM_W'(den_ff >> 1);
   assign num_r = (NUM_W'(pp_gy_ff) << F) + NUM_W'(den_ff >> 1);

   assign step_p = gx_neg_ff ? -signed'({1'b0, quo_p}) : signed'({1'b0, quo_p});
   assign step_r = gy_neg_ff ? -signed'({1'b0, quo_r}) : signed'({1'b0, quo_r});
   assign diff_p = DIFF_W'(pitch_ff) + DIFF_W'(step_p) - DIFF_W'(acc_pitch_ff);
   assign diff_r = DIFF_W'(roll_ff) + DIFF_W'(step_r) - DIFF_W'(acc_roll_ff);

   assign rnd_p    = (sum_p_ff + ROUND_HALF) >>> 16;
   assign rnd_r    = (sum_r_ff + ROUND_HALF) >>> 16;
   assign sat_p    = clamp(rnd_p);
   assign sat_r    = clamp(rnd_r);
   assign pitch_in = ANG_W'(sat_p);
   assign roll_in  = ANG_W'(sat_r);

   assign div_start_in = (state_ff == S_MUL) && (cnt_ff == 5'(RAW_W - 1));
   assign cor_start_in = ((state_ff == S_SQRT) && (cnt_ff == 5'(ROOT_W - 1))) ||
                         ((state_ff == S_PITCH) && cor_done);
   // load the result register when it is free or being read this cycle
   assign rsp_load     = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_chan.ready);
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_chan.ready);

   icf_cordic #(
      .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
      .CORDIC_STEPS    (CORDIC_STEPS),
      .IN_W            (COR_IN_W)
   ) u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cor_start_ff),
      .y_in  (cor_y),
      .x_in  (cor_x),
      .busy  (cor_busy),
      .done  (cor_done),
      .angle (cor_angle)
   );

   icf_gyro_div #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W)
   ) u_gyro_div (
      .clock (clock),
      .reset (reset),
      .start (div_start_ff),
      .den   (den_ff),
      .num_a (num_p),
      .num_b (num_r),
      .busy  (div_busy),
      .quo_a (quo_p),
      .quo_b (quo_r)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         weight_ff    <= WEIGHT_RESET;
         cpd_ff       <= CPD_RESET;
         pitch_ff     <= '0;
         roll_ff      <= '0;
         cor_start_ff <= 1'b0;
         div_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cor_start_ff <= cor_start_in;
         div_start_ff <= div_start_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            case (csr_index)
               CSR_GYRO_WEIGHT: weight_ff <= csr_wr_data;
               CSR_GYRO_CPD:    cpd_ff    <= csr_wr_data[CPD_W-1:0];
               default: ;
            endcase
         end

         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  ax_ff     <= req_chan.accel_x;
                  ay_ff     <= req_chan.accel_y;
                  az_ff     <= req_chan.accel_z;
                  gx_neg_ff <= req_chan.gyro_x[RAW_W-1];
                  gy_neg_ff <= req_chan.gyro_y[RAW_W-1];
                  mc_ax_ff  <= SQ_W'(mag16(req_chan.accel_x));
                  ml_ax_ff  <= mag16(req_chan.accel_x);
                  mc_az_ff  <= SQ_W'(mag16(req_chan.accel_z));
                  ml_az_ff  <= mag16(req_chan.accel_z);
                  mc_dt_ff  <= PROD_W'(req_chan.interval_us);
                  ml_gx_ff  <= mag16(req_chan.gyro_x);
                  ml_gy_ff  <= mag16(req_chan.gyro_y);
                  mc_mic_ff <= DEN_W'(MICROS);
                  ml_cpd_ff <= cpd_eff;
                  sq_ff     <= '0;
                  pp_gx_ff  <= '0;
                  pp_gy_ff  <= '0;
                  den_ff    <= '0;
                  cnt_ff    <= '0;
                  state_ff  <= S_MUL;
               end
            end
            S_MUL: begin
               // shift-add: multiplier bits out the bottom, multiplicands climb
               sq_ff     <= sq_in;
               pp_gx_ff  <= pp_gx_ff + (ml_gx_ff[0] ? mc_dt_ff : '0);
               pp_gy_ff  <= pp_gy_ff + (ml_gy_ff[0] ? mc_dt_ff : '0);
               den_ff    <= den_ff + (ml_cpd_ff[0] ? mc_mic_ff : '0);
               mc_ax_ff  <= mc_ax_ff << 1;
               mc_az_ff  <= mc_az_ff << 1;
               mc_dt_ff  <= mc_dt_ff << 1;
               mc_mic_ff <= mc_mic_ff << 1;
               ml_ax_ff  <= ml_ax_ff >> 1;
               ml_az_ff  <= ml_az_ff >> 1;
               ml_gx_ff  <= ml_gx_ff >> 1;
               ml_gy_ff  <= ml_gy_ff >> 1;
               ml_cpd_ff <= ml_cpd_ff >> 1;
               if (cnt_ff == 5'(RAW_W - 1)) begin
                  rad_ff   <= {sq_in, 16'd0};
                  root_ff  <= '0;
                  rem_ff   <= '0;
                  cnt_ff   <= '0;
                  state_ff <= S_SQRT;
               end else begin
                  cnt_ff   <= cnt_ff + 5'd1;
               end
            end
            S_SQRT: begin
               rem_ff  <= sqrt_ge ? REM_W'(rem_t - trial) : REM_W'(rem_t);
               root_ff <= {root_ff[ROOT_W-2:0], sqrt_ge};
               rad_ff  <= rad_ff << 2;
               cnt_ff  <= cnt_ff + 5'd1;
               if (cnt_ff == 5'(ROOT_W - 1)) begin
                  state_ff <= S_PITCH;
               end
            end
            S_PITCH: begin
               if (cor_done) begin
                  acc_pitch_ff <= cor_angle;
                  state_ff     <= S_ROLL;
               end
            end
            S_ROLL: begin
               if (cor_done) begin
                  acc_roll_ff <= cor_angle;
                  state_ff    <= S_WAIT_DIV;
               end
            end
            S_WAIT_DIV: begin
               // sum = acc*2^16 + w*(prev + step - acc)
               if (!div_busy) begin
                  w_sh_ff  <= w_eff;
                  dp_sh_ff <= BL_W'(diff_p);
                  dr_sh_ff <= BL_W'(diff_r);
                  sum_p_ff <= BL_W'(acc_pitch_ff) <<< 16;
                  sum_r_ff <= BL_W'(acc_roll_ff) <<< 16;
                  cnt_ff   <= '0;
                  state_ff <= S_BLEND;
               end
            end
            S_BLEND: begin
               if (w_sh_ff[0]) begin
                  sum_p_ff <= sum_p_ff + dp_sh_ff;
                  sum_r_ff <= sum_r_ff + dr_sh_ff;
               end
               dp_sh_ff <= dp_sh_ff <<< 1;
               dr_sh_ff <= dr_sh_ff <<< 1;
               w_sh_ff  <= w_sh_ff >> 1;
               cnt_ff   <= cnt_ff + 5'd1;
               if (cnt_ff == 5'(WEIGHT_W - 1)) begin
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               // hold until the result register is free
               if (rsp_load) begin
                  pitch_ff     <= pitch_in;
                  roll_ff      <= roll_in;
                  rsp_pitch_ff <= ANGLE_OUT_W'(pitch_in);
                  rsp_roll_ff  <= ANGLE_OUT_W'(roll_in);
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_chan.ready     = (state_ff == S_IDLE);
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.pitch_out = rsp_pitch_ff;
   assign rsp_chan.roll_out  = rsp_roll_ff;

   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      (pitch_ff <= LIMIT) && (pitch_ff >= -LIMIT) && (roll_ff <= LIMIT) && (roll_ff >= -LIMIT))
      else $error("filtered angle beyond saturation limit");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_MUL))
      else $error("accepted transaction did not start the multiply phase");

   a_cordic_free: assert property (@(posedge clock) disable iff (reset)
      cor_start_ff |-> !cor_busy)
      else $error("CORDIC started while busy");

   a_div_finished: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_BLEND) |-> !div_busy)
      else $error("blend running before the gyro divide finished");

   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_DONE))
      else $error("result raised outside the final state");

endmodule

`default_nettype wire
